### sv/mlr_pkg.sv
package mlr_pkg;

  // Matrix geometry: DIM must be a power of two
  localparam int DIM    = 32;
  localparam int IDX_W  = $clog2(DIM);
  localparam int LEN_W  = IDX_W + 1;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH  = DIM * DIM;

  // Field widths of the item
  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 2;
  localparam int FIDX_W  = 5;
  localparam int SHIFT_W = 5;
  localparam int CFG_W   = 6;

  // Configuration
  localparam int CFG_AW    = 1;
  localparam int CFG_RESET = 32;
  localparam logic [CFG_AW-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_COLS = 1'b1;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROT_ROW = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ROT_COL = 2'd3;

  // One access to the matrix store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  // One result item
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     index_error;
  } res_t;

endpackage

### sv/mlr_store.sv
module mlr_store (
  input  logic                      clk,
  input  mlr_pkg::mem_req_t         req,
  output logic [mlr_pkg::DATA_W-1:0] rdata
);

  logic [mlr_pkg::DATA_W-1:0] mem [0:mlr_pkg::DEPTH-1];

  // Single port, read-first, registered read
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rdata <= mem[req.addr];
  end

endmodule

### sv/mlr_ctrl.sv
module mlr_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mlr_pkg::FUNC_W-1:0]      in_func,
  input  logic [mlr_pkg::FIDX_W-1:0]      in_row,
  input  logic [mlr_pkg::FIDX_W-1:0]      in_col,
  input  logic [mlr_pkg::DATA_W-1:0]      in_value,
  input  logic [mlr_pkg::SHIFT_W-1:0]     in_amount,
  input  logic                            in_toward,
  input  logic [mlr_pkg::LEN_W-1:0]       nr,
  input  logic [mlr_pkg::LEN_W-1:0]       nc,
  output logic                            res_valid,
  input  logic                            res_ready,
  output mlr_pkg::res_t                   res,
  output mlr_pkg::mem_req_t               mem_req,
  input  logic [mlr_pkg::DATA_W-1:0]      mem_rdata
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RDWAIT  = 3'd1;
  localparam logic [2:0] ST_MOD     = 3'd2;
  localparam logic [2:0] ST_GATHER  = 3'd3;
  localparam logic [2:0] ST_GAP     = 3'd4;
  localparam logic [2:0] ST_SCATTER = 3'd5;
  localparam logic [2:0] ST_FLUSH   = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  localparam int IW = mlr_pkg::IDX_W;
  localparam int LW = mlr_pkg::LEN_W;
  localparam int SW = mlr_pkg::SHIFT_W;

  logic [2:0]                 state_r, state_nxt;
  logic                       is_col_r, is_col_nxt;
  logic [IW-1:0]              fix_r, fix_nxt;
  logic [LW-1:0]              len_r, len_nxt;
  logic [SW-1:0]              p_r, p_nxt;
  logic                       toward_r, toward_nxt;
  logic [IW-1:0]              k_r, k_nxt;
  logic [IW-1:0]              ptr_r, ptr_nxt;
  logic                       gv_r, gv_nxt;
  logic [IW-1:0]              gk_r;
  logic                       sv_r, sv_nxt;
  logic [IW-1:0]              sk_r;
  logic [mlr_pkg::DATA_W-1:0] lq_r;
  logic [mlr_pkg::DATA_W-1:0] res_data_r, res_data_nxt;
  logic                       res_err_r, res_err_nxt;

  logic [mlr_pkg::DATA_W-1:0] lbuf [0:mlr_pkg::DIM-1];

  logic    row_ok, col_ok, err;
  logic    accept;
  logic    k_last;
  logic    p_big;
  logic [IW-1:0] ptr_inc;

  function automatic logic [mlr_pkg::ADDR_W-1:0] line_addr(
    input logic          col_line,
    input logic [IW-1:0] fix,
    input logic [IW-1:0] pos
  );
    line_addr = col_line ? {pos, fix} : {fix, pos};
  endfunction

  // Index checks against the active size
  always_comb begin
    row_ok = 32'(in_row) < 32'(nr);
    col_ok = 32'(in_col) < 32'(nc);
    unique case (in_func)
      mlr_pkg::FUNC_WRITE,
      mlr_pkg::FUNC_READ:    err = !(row_ok && col_ok);
      mlr_pkg::FUNC_ROT_ROW: err = !row_ok;
      mlr_pkg::FUNC_ROT_COL: err = !col_ok;
      default:               err = 1'b1;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign res_valid = (state_r == ST_DONE);
  assign res.read_value  = res_data_r;
  assign res.index_error = res_err_r;

  assign k_last  = ({1'b0, k_r} + LW'(1)) == len_r;
  assign ptr_inc = (({1'b0, ptr_r} + LW'(1)) == len_r) ? '0 : ptr_r + IW'(1);
  assign p_big   = 32'(p_r) >= 32'(len_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    is_col_nxt   = is_col_r;
    fix_nxt      = fix_r;
    len_nxt      = len_r;
    p_nxt        = p_r;
    toward_nxt   = toward_r;
    k_nxt        = k_r;
    ptr_nxt      = ptr_r;
    res_data_nxt = res_data_r;
    res_err_nxt  = res_err_r;
    gv_nxt       = 1'b0;
    sv_nxt       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_data_nxt = '0;
          res_err_nxt  = err;
          is_col_nxt   = (in_func == mlr_pkg::FUNC_ROT_COL);
          fix_nxt      = (in_func == mlr_pkg::FUNC_ROT_COL) ? IW'(in_col) : IW'(in_row);
          len_nxt      = (in_func == mlr_pkg::FUNC_ROT_COL) ? nr : nc;
          p_nxt        = in_amount;
          toward_nxt   = in_toward;
          if (err || in_func == mlr_pkg::FUNC_WRITE) begin
            state_nxt = ST_DONE;
          end else if (in_func == mlr_pkg::FUNC_READ) begin
            state_nxt = ST_RDWAIT;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_RDWAIT: begin
        res_data_nxt = mem_rdata;
        state_nxt    = ST_DONE;
      end
      ST_MOD: begin
        // amount modulo line length, one subtraction a cycle
        if (p_big) begin
          p_nxt = p_r - SW'(len_r);
        end else begin
          k_nxt = '0;
          if (toward_r || p_r == '0) begin
            ptr_nxt = IW'(p_r);
          end else begin
            ptr_nxt = IW'(len_r - LW'(p_r));
          end
          state_nxt = ST_GATHER;
        end
      end
      ST_GATHER: begin
        gv_nxt = 1'b1;
        if (k_last) begin
          state_nxt = ST_GAP;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_GAP: begin
        k_nxt     = '0;
        state_nxt = ST_SCATTER;
      end
      ST_SCATTER: begin
        sv_nxt  = 1'b1;
        ptr_nxt = ptr_inc;
        if (k_last) begin
          state_nxt = ST_FLUSH;
        end else begin
          k_nxt = k_r + IW'(1);
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Matrix store access
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = line_addr(is_col_r, fix_r, k_r);
    mem_req.wdata = lq_r;
    if (state_r == ST_IDLE) begin
      mem_req.addr  = {IW'(in_row), IW'(in_col)};
      mem_req.wdata = in_value;
      mem_req.we    = accept && !err && (in_func == mlr_pkg::FUNC_WRITE);
    end else if (sv_r) begin
      mem_req.we   = 1'b1;
      mem_req.addr = line_addr(is_col_r, fix_r, sk_r);
    end
  end

  // Line buffer: filled from the store, read back in rotated order
  always_ff @(posedge clk) begin
    if (gv_r) begin
      lbuf[gk_r] <= mem_rdata;
    end
    lq_r <= lbuf[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gv_r    <= 1'b0;
      sv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gv_r    <= gv_nxt;
      sv_r    <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_col_r   <= is_col_nxt;
    fix_r      <= fix_nxt;
    len_r      <= len_nxt;
    p_r        <= p_nxt;
    toward_r   <= toward_nxt;
    k_r        <= k_nxt;
    ptr_r      <= ptr_nxt;
    gk_r       <= k_r;
    sk_r       <= k_r;
    res_data_r <= res_data_nxt;
    res_err_r  <= res_err_nxt;
  end

endmodule

### sv/matrix_line_rotator.sv
// Channel  Dir  Handshake           Payload
// in_      in   in_tvalid/tready    tdata: row, col, value, shift, toward; tuser: func
// out_     out  out_tvalid/tready   tdata: read_value, index_error
// cfg_     in   cfg_we              cfg_addr selects rows_in_use / cols_in_use
//
// A rotation of a line of L elements first reduces the amount modulo L by repeated
// subtraction, then passes the line through the single port of the matrix store
// into a buffer and back in rotated order (gather, then scatter).
// Reset is synchronous, active low; it clears control state and sets both sizes to 32.
// A result waits in the output register while the next item is accepted; that
// item stalls at its end until the output register is free.
module matrix_line_rotator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // row_index[4:0], col_index[9:5], elem_value[41:10], shift_amount[46:42],
  // toward_start[47]
  input  logic [47:0]                     in_tdata,
  // func[1:0]
  input  logic [mlr_pkg::FUNC_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // read_value[31:0], index_error[32], zero pad [39:33]
  output logic [39:0]                     out_tdata,
  input  logic                            cfg_we,
  input  logic [mlr_pkg::CFG_AW-1:0]      cfg_addr,
  input  logic [mlr_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int LW = mlr_pkg::LEN_W;

  logic [mlr_pkg::CFG_W-1:0]  rows_r, rows_nxt;
  logic [mlr_pkg::CFG_W-1:0]  cols_r, cols_nxt;
  logic [LW-1:0]              nr, nc;
  logic                       res_valid, res_ready;
  mlr_pkg::res_t              res;
  mlr_pkg::mem_req_t          mem_req;
  logic [mlr_pkg::DATA_W-1:0] mem_rdata;
  logic                       out_valid_r, out_valid_nxt;
  mlr_pkg::res_t              out_data_r;

  function automatic logic [LW-1:0] active_len(input logic [mlr_pkg::CFG_W-1:0] v);
    if (v == '0) begin
      active_len = LW'(1);
    end else if (32'(v) > 32'(mlr_pkg::DIM)) begin
      active_len = LW'(mlr_pkg::DIM);
    end else begin
      active_len = LW'(v);
    end
  endfunction

  // Configuration registers
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        mlr_pkg::CFG_ROWS: rows_nxt = cfg_wdata;
        mlr_pkg::CFG_COLS: cols_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nr = active_len(rows_r);
  assign nc = active_len(cols_r);

  // Output register
  assign res_ready     = !out_valid_r || out_tready;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= mlr_pkg::CFG_W'(mlr_pkg::CFG_RESET);
      cols_r      <= mlr_pkg::CFG_W'(mlr_pkg::CFG_RESET);
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.index_error, out_data_r.read_value};

  mlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_row    (in_tdata[4:0]),
    .in_col    (in_tdata[9:5]),
    .in_value  (in_tdata[41:10]),
    .in_amount (in_tdata[46:42]),
    .in_toward (in_tdata[47]),
    .nr        (nr),
    .nc        (nc),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  mlr_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

### tb/testbench.sv
module testbench;

  // Cycles without any accepted item, delivered result or register write before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  // Long receiver hold-off, started once the block is well into its work
  localparam int HOLD_CYCLES = 500;
  localparam int HOLD_AT     = 60;

  // Payload in the same bit order as in_tdata, lowest field last
  typedef struct packed {
    logic                              toward;
    logic [mlr_pkg::SHIFT_W-1:0]       shift;
    logic signed [mlr_pkg::DATA_W-1:0] value;
    logic [mlr_pkg::FIDX_W-1:0]        col;
    logic [mlr_pkg::FIDX_W-1:0]        row;
  } op_body_t;

  typedef struct packed {
    logic [mlr_pkg::FUNC_W-1:0] func;
    op_body_t                   body;
  } matrix_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic [mlr_pkg::FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [mlr_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [mlr_pkg::CFG_W-1:0] cfg_wdata = '0;

  matrix_op_t    ops_to_send[$];
  mlr_pkg::res_t due_results[$];

  // Predicted contents of the block
  logic signed [mlr_pkg::DATA_W-1:0] mat_model [mlr_pkg::DEPTH];
  logic [mlr_pkg::CFG_W-1:0] rows_reg = mlr_pkg::CFG_W'(mlr_pkg::CFG_RESET);
  logic [mlr_pkg::CFG_W-1:0] cols_reg = mlr_pkg::CFG_W'(mlr_pkg::CFG_RESET);

  // Stimulus side: active size of the current phase and which elements hold data
  int gen_rows = mlr_pkg::DIM;
  int gen_cols = mlr_pkg::DIM;
  bit written [mlr_pkg::DEPTH];

  int fail_count = 0;
  int result_count = 0;
  int send_gap = 0;
  int sink_gap = 0;
  int quiet = 0;
  int tick = 0;
  bit calm = 1'b0;
  bit held = 1'b0;

  int rows_plan [8]  = '{32, 1, 0, 63, 1, 32, 5, 17};
  int cols_plan [8]  = '{32, 1, 63, 0, 32, 1, 7, 33};
  int count_plan [8] = '{500, 120, 120, 250, 250, 250, 220, 200};

  always #1 clk = ~clk;

  matrix_line_rotator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Register value to active size: zero acts as one, above DIM as DIM
  function automatic int eff_size(logic [mlr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > mlr_pkg::DIM) return mlr_pkg::DIM;
    return int'(v);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one item to the predicted matrix and return its result
  function automatic mlr_pkg::res_t apply_matrix_op(matrix_op_t op);
    mlr_pkg::res_t r;
    int nr, nc, len, p, from, k, a;
    bit is_row;
    logic signed [mlr_pkg::DATA_W-1:0] line [mlr_pkg::DIM];
    nr = eff_size(rows_reg);
    nc = eff_size(cols_reg);
    r.read_value = '0;
    r.index_error = 1'b0;
    case (op.func)
      mlr_pkg::FUNC_WRITE: begin
        if (op.body.row >= nr || op.body.col >= nc) r.index_error = 1'b1;
        else mat_model[op.body.row * mlr_pkg::DIM + op.body.col] = op.body.value;
      end
      mlr_pkg::FUNC_READ: begin
        if (op.body.row >= nr || op.body.col >= nc) r.index_error = 1'b1;
        else r.read_value = mat_model[op.body.row * mlr_pkg::DIM + op.body.col];
      end
      default: begin
        // row rotation checks only the row, column rotation only the column
        is_row = (op.func == mlr_pkg::FUNC_ROT_ROW);
        if (is_row ? (op.body.row >= nr) : (op.body.col >= nc)) begin
          r.index_error = 1'b1;
        end else begin
          len = is_row ? nc : nr;
          p = int'(op.body.shift) % len;
          for (k = 0; k < len; k++) begin
            a = is_row ? int'(op.body.row) * mlr_pkg::DIM + k
                       : k * mlr_pkg::DIM + int'(op.body.col);
            line[k] = mat_model[a];
          end
          for (k = 0; k < len; k++) begin
            a = is_row ? int'(op.body.row) * mlr_pkg::DIM + k
                       : k * mlr_pkg::DIM + int'(op.body.col);
            from = op.body.toward ? (k + p) % len : (k + len - p) % len;
            mat_model[a] = line[from];
          end
        end
      end
    endcase
    return r;
  endfunction

  // First element of a line that was never written, or -1
  function automatic int first_hole(bit is_row, int idx);
    int a;
    for (int k = 0; k < (is_row ? gen_cols : gen_rows); k++) begin
      a = is_row ? idx * mlr_pkg::DIM + k : k * mlr_pkg::DIM + idx;
      if (!written[a]) return a;
    end
    return -1;
  endfunction

  task automatic push_op(logic [mlr_pkg::FUNC_W-1:0] func, int row, int col,
                         logic [mlr_pkg::DATA_W-1:0] value, int shift, bit toward);
    matrix_op_t op;
    op.func = func;
    op.body.row = row[mlr_pkg::FIDX_W-1:0];
    op.body.col = col[mlr_pkg::FIDX_W-1:0];
    op.body.value = value;
    op.body.shift = shift[mlr_pkg::SHIFT_W-1:0];
    op.body.toward = toward;
    ops_to_send.push_back(op);
    if (func == mlr_pkg::FUNC_WRITE && row < gen_rows && col < gen_cols) begin
      written[row * mlr_pkg::DIM + col] = 1'b1;
    end
  endtask

  // Random item; a read or rotation that would touch unwritten data becomes a write
  task automatic make_random_op();
    int f, row, col, hole, pick;
    pick = $urandom_range(0, 99);
    f = pick < 35 ? int'(mlr_pkg::FUNC_WRITE) :
        pick < 60 ? int'(mlr_pkg::FUNC_READ) :
        pick < 80 ? int'(mlr_pkg::FUNC_ROT_ROW) : int'(mlr_pkg::FUNC_ROT_COL);
    row = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_rows - 1) : $urandom_range(0, 31);
    col = ($urandom_range(0, 99) < 85) ? $urandom_range(0, gen_cols - 1) : $urandom_range(0, 31);
    if (f == mlr_pkg::FUNC_READ && row < gen_rows && col < gen_cols &&
        !written[row * mlr_pkg::DIM + col]) begin
      f = int'(mlr_pkg::FUNC_WRITE);
    end else if (f == mlr_pkg::FUNC_ROT_ROW && row < gen_rows) begin
      hole = first_hole(1'b1, row);
      if (hole >= 0) begin
        f = int'(mlr_pkg::FUNC_WRITE);
        col = hole % mlr_pkg::DIM;
      end
    end else if (f == mlr_pkg::FUNC_ROT_COL && col < gen_cols) begin
      hole = first_hole(1'b0, col);
      if (hole >= 0) begin
        f = int'(mlr_pkg::FUNC_WRITE);
        row = hole / mlr_pkg::DIM;
      end
    end
    push_op(f[mlr_pkg::FUNC_W-1:0], row, col, $urandom, $urandom_range(0, 31),
            1'($urandom_range(0, 1)));
  endtask

  task automatic cfg_write(logic [mlr_pkg::CFG_AW-1:0] idx, int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v[mlr_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(int r, int c);
    cfg_write(mlr_pkg::CFG_ROWS, r);
    cfg_write(mlr_pkg::CFG_COLS, c);
    gen_rows = eff_size(r[mlr_pkg::CFG_W-1:0]);
    gen_cols = eff_size(c[mlr_pkg::CFG_W-1:0]);
  endtask

  // Block idle: nothing queued, nothing offered, no result outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (ops_to_send.size() != 0 || due_results.size() != 0 || in_tvalid);
  endtask

  // Stretches with no idling on either side
  always @(posedge clk) begin
    tick <= tick + 1;
    if (tick % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
  end

  // Item driver
  always @(posedge clk) begin : drive_items
    matrix_op_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (ops_to_send.size() != 0) begin
        nxt = ops_to_send.pop_front();
        in_tuser <= nxt.func;
        in_tdata <= nxt.body;
        in_tvalid <= 1'b1;
        send_gap <= calm ? 0 : pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap <= 0;
    end else if (result_count == HOLD_AT && !held) begin
      held <= 1'b1;
      sink_gap <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 2) == 0) sink_gap <= pick_gap();
    end
  end

  // Track register writes
  always @(posedge clk) begin
    if (rst_n && cfg_we) begin
      if (cfg_addr == mlr_pkg::CFG_ROWS) rows_reg <= cfg_wdata;
      else if (cfg_addr == mlr_pkg::CFG_COLS) cols_reg <= cfg_wdata;
    end
  end

  // Predict each accepted item
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      due_results.push_back(apply_matrix_op({in_tuser, in_tdata}));
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin : check_results
    mlr_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      result_count <= result_count + 1;
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: read_value %h index_error %b",
                 $time, out_tdata[31:0], out_tdata[32]);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (out_tdata[31:0] !== want.read_value) begin
          $display("%0t: read_value expected %h got %h", $time, want.read_value, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[32] !== want.index_error) begin
          $display("%0t: index_error expected %b got %b", $time, want.index_error, out_tdata[32]);
          fail_count++;
        end
      end
    end
  end

  // Hang detection
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: 2 x 3 matrix, field extremes, every operation, bad indexes
    set_size(2, 3);
    push_op(mlr_pkg::FUNC_WRITE, 0, 0, 32'h8000_0000, 0, 1'b0);
    push_op(mlr_pkg::FUNC_WRITE, 0, 1, 32'h7fff_ffff, 0, 1'b0);
    push_op(mlr_pkg::FUNC_WRITE, 0, 2, 32'h0000_0000, 0, 1'b0);
    push_op(mlr_pkg::FUNC_WRITE, 1, 0, 32'hffff_ffff, 0, 1'b0);
    push_op(mlr_pkg::FUNC_WRITE, 1, 1, 32'h0000_0001, 31, 1'b1);
    push_op(mlr_pkg::FUNC_WRITE, 1, 2, 32'h1234_5678, 0, 1'b0);
    push_op(mlr_pkg::FUNC_READ, 0, 1, 32'h0, 0, 1'b0);
    // indexes outside the active size
    push_op(mlr_pkg::FUNC_WRITE, 2, 0, 32'hdead_beef, 0, 1'b0);
    push_op(mlr_pkg::FUNC_WRITE, 0, 3, 32'hdead_beef, 0, 1'b0);
    push_op(mlr_pkg::FUNC_READ, 31, 31, 32'h5a5a_5a5a, 31, 1'b1);
    // row rotations: one place, large shift, none, a full turn
    push_op(mlr_pkg::FUNC_ROT_ROW, 0, 0, 32'h0, 1, 1'b1);
    push_op(mlr_pkg::FUNC_ROT_ROW, 1, 0, 32'h0, 31, 1'b0);
    push_op(mlr_pkg::FUNC_ROT_ROW, 0, 0, 32'h0, 0, 1'b1);
    push_op(mlr_pkg::FUNC_ROT_ROW, 1, 0, 32'h0, 3, 1'b1);
    // column rotations, the unused index is ignored; then a column and a row outside the active size
    push_op(mlr_pkg::FUNC_ROT_COL, 0, 2, 32'h0, 1, 1'b0);
    push_op(mlr_pkg::FUNC_ROT_COL, 31, 1, 32'h0, 5, 1'b1);
    push_op(mlr_pkg::FUNC_ROT_COL, 0, 3, 32'h0, 1, 1'b0);
    push_op(mlr_pkg::FUNC_ROT_ROW, 5, 31, 32'h0, 1, 1'b1);
    push_op(mlr_pkg::FUNC_READ, 0, 0, 32'h0, 0, 1'b0);
    push_op(mlr_pkg::FUNC_READ, 1, 2, 32'h0, 0, 1'b0);
    push_op(mlr_pkg::FUNC_READ, 0, 2, 32'h0, 0, 1'b0);
    push_op(mlr_pkg::FUNC_READ, 1, 1, 32'h0, 0, 1'b0);

    // Random phases over several sizes; stored elements survive resizing
    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      set_size(rows_plan[ph], cols_plan[ph]);
      repeat (count_plan[ph]) make_random_op();
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
sv/mlr_pkg.sv
sv/mlr_store.sv
sv/mlr_ctrl.sv
sv/matrix_line_rotator.sv
tb/testbench.sv
